/* sv/datrie_pkg.sv */
package datrie_pkg;

	// item field widths
	localparam int OP_W    = 2;
	localparam int IDX_W   = 16;
	localparam int WORD_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int VALUE_W = 31;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_KEY   = 2'd1;
	localparam logic [OP_W-1:0] OP_END   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_NODE  = 1'b1;

	// result kinds
	localparam logic KIND_PREFIX = 1'b0;
	localparam logic KIND_FINAL  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BEGIN,
		ST_START_WT,
		ST_CHECK,
		ST_LEAF_WT,
		ST_STEP,
		ST_STEP_WT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;     // capture item, perform table write
		logic clr_we;     // clearing pass write
		logic rd_start;   // read entry at start node
		logic rd_leaf;    // read entry at current base
		logic rd_step;    // read entry at transition index
		logic ld_start;   // load current base from start entry
		logic start_oor;  // start node out of table
		logic res_clr;    // no match pending
		logic ld_leaf;    // latch leaf test
		logic ld_step;    // apply transition check
		logic step_fail;  // transition index out of table
		logic emit;       // load output register
		logic end_clear;  // close the key
	} ctrl_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic started;
		logic failed;
		logic mode;
		logic start_oor;
		logic cb_in_range;
		logic p_in_range;
		logic res_found;
		logic out_free;
		logic clr_done;
	} ctrl_sts_t;

endpackage

/* sv/datrie_req_if.sv */
interface datrie_req_if;
	logic                            valid;
	logic                            ready;
	logic [datrie_pkg::OP_W-1:0]     operation;
	logic [datrie_pkg::IDX_W-1:0]    entry_index;
	logic signed [datrie_pkg::WORD_W-1:0] base_word;
	logic signed [datrie_pkg::WORD_W-1:0] check_word;
	logic [datrie_pkg::BYTE_W-1:0]   key_byte;

	modport source(output valid, operation, entry_index, base_word, check_word, key_byte,
		input ready);
	modport sink(input valid, operation, entry_index, base_word, check_word, key_byte,
		output ready);
endinterface

/* sv/datrie_rsp_if.sv */
interface datrie_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             result_kind;
	logic                             found;
	logic [datrie_pkg::VALUE_W-1:0]   match_value;

	modport source(output valid, result_kind, found, match_value, input ready);
	modport sink(input valid, result_kind, found, match_value, output ready);
endinterface

/* sv/datrie_cfg_if.sv */
interface datrie_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [datrie_pkg::CFG_IDX_W-1:0]   index;
	logic [datrie_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* sv/datrie_ram.sv */
module datrie_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/datrie_ctrl.sv */
module datrie_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  datrie_pkg::ctrl_sts_t sts,
	output datrie_pkg::ctrl_cmd_t cmd
);

	datrie_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= datrie_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			datrie_pkg::ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_done) state_d = datrie_pkg::ST_IDLE;
			end
			datrie_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = datrie_pkg::ST_BEGIN;
				end
			end
			datrie_pkg::ST_BEGIN: begin
				// captured op decides; table writes finish at accept
				if (!(sts.op inside {datrie_pkg::OP_KEY, datrie_pkg::OP_END})) begin
					state_d = datrie_pkg::ST_IDLE;
				end else if (sts.started) begin
					state_d = datrie_pkg::ST_CHECK;
				end else if (sts.start_oor) begin
					cmd.start_oor = 1'b1;
					state_d = datrie_pkg::ST_CHECK;
				end else begin
					cmd.rd_start = 1'b1;
					state_d = datrie_pkg::ST_START_WT;
				end
			end
			datrie_pkg::ST_START_WT: begin
				cmd.ld_start = 1'b1;
				state_d = datrie_pkg::ST_CHECK;
			end
			datrie_pkg::ST_CHECK: begin
				cmd.res_clr = 1'b1;
				if (sts.op == datrie_pkg::OP_KEY) begin
					if (sts.failed) begin
						state_d = datrie_pkg::ST_IDLE;
					end else if (sts.mode && sts.cb_in_range) begin
						cmd.rd_leaf = 1'b1;
						state_d = datrie_pkg::ST_LEAF_WT;
					end else begin
						state_d = datrie_pkg::ST_STEP;
					end
				end else begin
					if (!sts.failed && sts.cb_in_range) begin
						cmd.rd_leaf = 1'b1;
						state_d = datrie_pkg::ST_LEAF_WT;
					end else begin
						state_d = datrie_pkg::ST_EMIT;
					end
				end
			end
			datrie_pkg::ST_LEAF_WT: begin
				cmd.ld_leaf = 1'b1;
				if (sts.op == datrie_pkg::OP_KEY) state_d = datrie_pkg::ST_STEP;
				else state_d = datrie_pkg::ST_EMIT;
			end
			datrie_pkg::ST_STEP: begin
				if (sts.p_in_range) begin
					cmd.rd_step = 1'b1;
					state_d = datrie_pkg::ST_STEP_WT;
				end else begin
					cmd.step_fail = 1'b1;
					state_d = sts.res_found ? datrie_pkg::ST_EMIT : datrie_pkg::ST_IDLE;
				end
			end
			datrie_pkg::ST_STEP_WT: begin
				cmd.ld_step = 1'b1;
				state_d = sts.res_found ? datrie_pkg::ST_EMIT : datrie_pkg::ST_IDLE;
			end
			datrie_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.op == datrie_pkg::OP_END) cmd.end_clear = 1'b1;
					state_d = datrie_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = datrie_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/datrie_dp.sv */
module datrie_dp #(
	parameter int TABLE_DEPTH = 65536
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  datrie_pkg::ctrl_cmd_t                cmd,
	output datrie_pkg::ctrl_sts_t                sts,
	input  logic [datrie_pkg::OP_W-1:0]          operation,
	input  logic [datrie_pkg::IDX_W-1:0]         entry_index,
	input  logic signed [datrie_pkg::WORD_W-1:0] base_word,
	input  logic signed [datrie_pkg::WORD_W-1:0] check_word,
	input  logic [datrie_pkg::BYTE_W-1:0]        key_byte,
	input  logic                                 cfg_valid,
	input  logic [datrie_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [datrie_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic                                 result_kind,
	output logic                                 found,
	output logic [datrie_pkg::VALUE_W-1:0]       match_value
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int WW = datrie_pkg::WORD_W;
	localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);
	localparam logic [WW:0]   DEPTH_W  = (WW+1)'(TABLE_DEPTH);
	localparam logic [WW+1:0] DEPTH_P  = (WW+2)'(TABLE_DEPTH);

	logic [datrie_pkg::OP_W-1:0]       op_q;
	logic [datrie_pkg::BYTE_W-1:0]     byte_q;
	logic [WW-1:0]                     cb_q;
	logic                              started_q, failed_q;
	logic                              mode_q;
	logic [datrie_pkg::IDX_W-1:0]      start_q;
	logic [AW-1:0]                     clr_q;
	logic                              res_found_q;
	logic [datrie_pkg::VALUE_W-1:0]    res_value_q;
	logic                              out_valid_q, out_kind_q, out_found_q;
	logic [datrie_pkg::VALUE_W-1:0]    out_value_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [2*WW-1:0]   ram_wdata, ram_rdata;
	logic [WW-1:0]     rd_base, rd_check;
	logic [WW+1:0]     p_ext;
	logic              wr_in_range, leaf_hit;

	assign rd_base  = ram_rdata[2*WW-1:WW];
	assign rd_check = ram_rdata[WW-1:0];

	// p = signed base + byte + 1, two guard bits
	assign p_ext = {{2{cb_q[WW-1]}}, cb_q} + (WW+2)'(byte_q) + (WW+2)'(1);
	assign wr_in_range = (WW+1)'(entry_index) < DEPTH_W;
	assign leaf_hit = (rd_check == cb_q) && rd_base[WW-1];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(entry_index);
		ram_wdata = {base_word, check_word};
		if (cmd.clr_we) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (cmd.accept && operation == datrie_pkg::OP_WRITE && wr_in_range) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		ram_raddr = '0;
		if (cmd.rd_start) ram_raddr = AW'(start_q);
		else if (cmd.rd_leaf) ram_raddr = cb_q[AW-1:0];
		else if (cmd.rd_step) ram_raddr = p_ext[AW-1:0];
	end

	datrie_ram #(
		.WIDTH(2*WW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= datrie_pkg::OP_WRITE;
			cb_q        <= '0;
			started_q   <= 1'b0;
			failed_q    <= 1'b0;
			mode_q      <= 1'b0;
			start_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_we) clr_q <= clr_q + AW'(1);
			if (cmd.accept) op_q <= operation;
			if (cfg_valid) begin
				case (cfg_index)
					datrie_pkg::CFG_SEARCH_MODE: mode_q <= cfg_data[0];
					datrie_pkg::CFG_START_NODE:  start_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.start_oor) begin
				started_q <= 1'b1;
				failed_q  <= 1'b1;
				cb_q      <= '0;
			end
			if (cmd.ld_start) begin
				started_q <= 1'b1;
				failed_q  <= 1'b0;
				cb_q      <= rd_base;
			end
			if (cmd.ld_step) begin
				if (rd_check == cb_q) cb_q <= rd_base;
				else failed_q <= 1'b1;
			end
			if (cmd.step_fail) failed_q <= 1'b1;
			if (cmd.end_clear) begin
				started_q <= 1'b0;
				failed_q  <= 1'b0;
				cb_q      <= '0;
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) byte_q <= key_byte;
		if (cmd.res_clr) begin
			res_found_q <= 1'b0;
			res_value_q <= '0;
		end
		if (cmd.ld_leaf) begin
			res_found_q <= leaf_hit;
			res_value_q <= leaf_hit ? ~rd_base[datrie_pkg::VALUE_W-1:0] : '0;
		end
		if (cmd.emit) begin
			out_kind_q  <= (op_q == datrie_pkg::OP_END) ? datrie_pkg::KIND_FINAL
				: datrie_pkg::KIND_PREFIX;
			out_found_q <= res_found_q;
			out_value_q <= res_value_q;
		end
	end

	assign sts.op          = op_q;
	assign sts.started     = started_q;
	assign sts.failed      = failed_q;
	assign sts.mode        = mode_q;
	assign sts.start_oor   = (WW+1)'(start_q) >= DEPTH_W;
	assign sts.cb_in_range = !cb_q[WW-1] && ((WW+1)'(cb_q) < DEPTH_W);
	assign sts.p_in_range  = !p_ext[WW+1] && (p_ext < DEPTH_P);
	assign sts.res_found   = res_found_q;
	assign sts.out_free    = !out_valid_q || out_ready;
	assign sts.clr_done    = (clr_q == CLR_LAST);

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign found       = out_found_q;
	assign match_value = out_value_q;

endmodule

/* sv/double_array_trie_search.sv */
// channel | dir | beat payload
// req     | in  | operation, entry_index, base_word, check_word, key_byte
// rsp     | out | result_kind, found, match_value
// cfg     | in  | index (0 search_mode, 1 start_node), data
//
// After reset a clearing pass zeroes the tables, with req.ready low.
// A table write is done when the beat is accepted. A key byte reads the start node on the
// first byte of a key, then the leaf at the current node in prefix mode, then the
// transition entry, and sends a prefix match when one is found; a failed key reads nothing.
// An end beat reads the leaf and sends the result. Each step waits one read of the table.
// A result sits in the rsp register; a new result waits only while it is held.
// cfg.ready is always high.
module double_array_trie_search #(
	parameter int TABLE_DEPTH = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	datrie_req_if.sink   req,
	datrie_rsp_if.source rsp,
	datrie_cfg_if.sink   cfg
);

	datrie_pkg::ctrl_cmd_t cmd;
	datrie_pkg::ctrl_sts_t sts;

	assign cfg.ready = 1'b1;

	datrie_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	datrie_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (req.operation),
		.entry_index(req.entry_index),
		.base_word  (req.base_word),
		.check_word (req.check_word),
		.key_byte   (req.key_byte),
		.cfg_valid  (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.result_kind(rsp.result_kind),
		.found      (rsp.found),
		.match_value(rsp.match_value)
	);

endmodule

/* verif/tb_double_array_trie_search.sv */
`timescale 1ns / 1ps

module tb_double_array_trie_search;

	localparam int TBL_DEPTH     = 65536;
	localparam int ITEM_TARGET   = 950;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 800000;
	localparam int BLOCK_SPAN    = 257;    // leaf slot plus 256 child slots
	localparam logic [datrie_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic [datrie_pkg::OP_W-1:0]   op;
		logic [datrie_pkg::IDX_W-1:0]  idx;
		logic [datrie_pkg::WORD_W-1:0] base_w;
		logic [datrie_pkg::WORD_W-1:0] check_w;
		logic [datrie_pkg::BYTE_W-1:0] kbyte;
	} trie_item_t;

	typedef struct packed {
		logic                           kind;
		logic                           found;
		logic [datrie_pkg::VALUE_W-1:0] value;
	} match_t;

	typedef struct {
		int                                 len;
		logic [7:0][datrie_pkg::BYTE_W-1:0] chars;
	} trie_key_t;

	logic clk = 1'b0;
	logic arst_n;

	datrie_req_if req_bus();
	datrie_rsp_if rsp_bus();
	datrie_cfg_if cfg_bus();

	double_array_trie_search #(.TABLE_DEPTH(TBL_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus),
		.cfg(cfg_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// lookup state mirrored from the block
	bit [datrie_pkg::WORD_W-1:0]   node_base_mem  [TBL_DEPTH];
	bit [datrie_pkg::WORD_W-1:0]   node_check_mem [TBL_DEPTH];
	logic [datrie_pkg::WORD_W-1:0] walk_base = '0;
	bit                            walk_failed;
	bit                            walk_open;
	bit                            prefix_mode;
	logic [datrie_pkg::IDX_W-1:0]  root_index = '0;

	match_t pending_matches [$];
	match_t seen_exp;
	int     error_count;
	int     items_sent;
	int     cycle_count;
	int     rsp_hold;
	bit     idle_on = 1'b1;

	// trie being built by the stimulus
	int                           trie_child [longint];
	int                           next_block;
	int                           trie_root;
	bit [datrie_pkg::BYTE_W-1:0]  alphabet [3];
	trie_key_t                    stored_keys [$];

	function automatic bit leaf_at_node(logic [datrie_pkg::WORD_W-1:0] b,
		output logic [datrie_pkg::VALUE_W-1:0] v);
		longint node;
		node = longint'($signed(b));
		v = '0;
		if (node < 0 || node >= TBL_DEPTH)
			return 1'b0;
		if (node_check_mem[node] != b || !node_base_mem[node][datrie_pkg::WORD_W-1])
			return 1'b0;
		v = ~node_base_mem[node][datrie_pkg::VALUE_W-1:0];
		return 1'b1;
	endfunction

	function automatic void open_walk();
		if (walk_open)
			return;
		walk_open = 1'b1;
		walk_failed = 1'b0;
		if (root_index >= TBL_DEPTH) begin
			walk_failed = 1'b1;
			walk_base = '0;
		end else begin
			walk_base = node_base_mem[root_index];
		end
	endfunction

	function automatic bit predict_match(trie_item_t it, output match_t m);
		logic [datrie_pkg::VALUE_W-1:0] v;
		longint p;
		bit hit;
		m = '0;
		hit = 1'b0;
		case (it.op)
		datrie_pkg::OP_WRITE: begin
			node_base_mem[it.idx] = it.base_w;
			node_check_mem[it.idx] = it.check_w;
		end
		datrie_pkg::OP_KEY: begin
			open_walk();
			if (!walk_failed) begin
				// leaf at the node we are leaving, before the transition
				if (prefix_mode && leaf_at_node(walk_base, v)) begin
					m.kind = datrie_pkg::KIND_PREFIX;
					m.found = 1'b1;
					m.value = v;
					hit = 1'b1;
				end
				p = longint'($signed(walk_base)) + longint'(it.kbyte) + 1;
				if (p < 0 || p >= TBL_DEPTH || node_check_mem[p] != walk_base)
					walk_failed = 1'b1;
				else
					walk_base = node_base_mem[p];
			end
		end
		datrie_pkg::OP_END: begin
			open_walk();
			m.kind = datrie_pkg::KIND_FINAL;
			if (!walk_failed && leaf_at_node(walk_base, v)) begin
				m.found = 1'b1;
				m.value = v;
			end
			walk_base = '0;
			walk_failed = 1'b0;
			walk_open = 1'b0;
			hit = 1'b1;
		end
		default: ;
		endcase
		return hit;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	function automatic trie_item_t mk_item(logic [datrie_pkg::OP_W-1:0] op);
		trie_item_t it;
		it.op = op;
		it.idx = datrie_pkg::IDX_W'($urandom);
		it.base_w = $urandom;
		it.check_w = $urandom;
		it.kbyte = datrie_pkg::BYTE_W'($urandom);
		return it;
	endfunction

	function automatic trie_item_t mk_write(logic [datrie_pkg::IDX_W-1:0] idx,
		logic [datrie_pkg::WORD_W-1:0] b, logic [datrie_pkg::WORD_W-1:0] c);
		trie_item_t it;
		it = mk_item(datrie_pkg::OP_WRITE);
		it.idx = idx;
		it.base_w = b;
		it.check_w = c;
		return it;
	endfunction

	function automatic trie_item_t mk_byte(logic [datrie_pkg::BYTE_W-1:0] c);
		trie_item_t it;
		it = mk_item(datrie_pkg::OP_KEY);
		it.kbyte = c;
		return it;
	endfunction

	// negative base encodes the stored value as -base-1
	function automatic logic [datrie_pkg::WORD_W-1:0] leaf_word(
		logic [datrie_pkg::VALUE_W-1:0] v);
		return ~{1'b0, v};
	endfunction

	function automatic logic [datrie_pkg::VALUE_W-1:0] rand_value();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return datrie_pkg::VALUE_W'($urandom);
	endfunction

	function automatic trie_key_t key_of(int len, logic [63:0] chars);
		trie_key_t k;
		k.len = len;
		k.chars = chars;
		return k;
	endfunction

	function automatic trie_key_t random_key(int max_len, bit wild);
		trie_key_t k;
		k.chars = '0;
		k.len = ($urandom_range(9) == 0) ? 0 : $urandom_range(max_len, 1);
		for (int i = 0; i < k.len; i++)
			k.chars[i] = wild ? datrie_pkg::BYTE_W'($urandom_range(255))
				: alphabet[$urandom_range(2)];
		return k;
	endfunction

	task automatic send_item(trie_item_t it);
		int gap;
		match_t m;
		gap = pick_gap();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid       <= 1'b1;
		req_bus.operation   <= it.op;
		req_bus.entry_index <= it.idx;
		req_bus.base_word   <= it.base_w;
		req_bus.check_word  <= it.check_w;
		req_bus.key_byte    <= it.kbyte;
		do @(posedge clk); while (!req_bus.ready);
		if (predict_match(it, m))
			pending_matches.insert(pending_matches.size(), m);
		if (it.op != OP_SPARE)
			items_sent++;
	endtask

	task automatic send_noise();
		if ($urandom_range(1))
			send_item(mk_item(OP_SPARE));
		else
			send_item(mk_write(datrie_pkg::IDX_W'($urandom), $urandom, $urandom));
	endtask

	task automatic search_key(trie_key_t k, bit with_noise);
		int at;
		at = with_noise ? $urandom_range(k.len) : -1;
		for (int i = 0; i < k.len; i++) begin
			if (i == at)
				send_noise();
			send_item(mk_byte(k.chars[i]));
		end
		if (at == k.len)
			send_noise();
		send_item(mk_item(datrie_pkg::OP_END));
	endtask

	// hold off until every result is back, then let a trailing key byte finish
	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_matches.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_search(bit mode, logic [datrie_pkg::IDX_W-1:0] start);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= datrie_pkg::CFG_SEARCH_MODE;
		cfg_bus.data  <= {(datrie_pkg::CFG_DATA_W-1)'($urandom), mode};
		do @(posedge clk); while (!cfg_bus.ready);
		prefix_mode = mode;
		cfg_bus.index <= datrie_pkg::CFG_START_NODE;
		cfg_bus.data  <= start;
		do @(posedge clk); while (!cfg_bus.ready);
		root_index = start;
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic insert_key(trie_key_t k);
		int b;
		int nb;
		longint slot;
		b = trie_root;
		for (int i = 0; i < k.len; i++) begin
			slot = longint'(b) * 256 + longint'(k.chars[i]);
			if (trie_child.exists(slot)) begin
				b = trie_child[slot];
			end else begin
				if (next_block + BLOCK_SPAN >= TBL_DEPTH)
					return;
				nb = next_block;
				next_block += BLOCK_SPAN;
				send_item(mk_write(datrie_pkg::IDX_W'(b + k.chars[i] + 1),
					datrie_pkg::WORD_W'(nb), datrie_pkg::WORD_W'(b)));
				trie_child[slot] = nb;
				b = nb;
			end
		end
		send_item(mk_write(datrie_pkg::IDX_W'(b), leaf_word(rand_value()),
			datrie_pkg::WORD_W'(b)));
		stored_keys.insert(stored_keys.size(), k);
	endtask

	task automatic test_empty_tables();
		// all-zero tables: every byte walks on, nothing is ever a leaf
		search_key(key_of(0, '0), 1'b0);
		search_key(key_of(3, 64'h80FF00), 1'b0);
	endtask

	task automatic test_directed_trie();
		wait_idle();
		program_search(1'b1, 16'd10);
		send_item(mk_write(16'd10, 32'd100, 32'hFFFF_FFFF));
		send_item(mk_write(16'd100, leaf_word('0), 32'd100));
		send_item(mk_write(16'd198, 32'd300, 32'd100));            // 'a'
		send_item(mk_write(16'd300, leaf_word(31'd5), 32'd300));
		send_item(mk_write(16'd399, 32'd500, 32'd300));            // 'b'
		send_item(mk_write(16'd500, 32'h8000_0000, 32'd500));      // largest value
		send_item(mk_write(16'd301, 32'd700, 32'd300));            // byte 0x00
		send_item(mk_write(16'd356, 32'd65400, 32'd100));          // byte 0xFF
		send_item(mk_write(16'd65411, 32'h8000_0001, 32'd65400));  // negative base
		send_item(mk_write(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		send_item(mk_write(16'd0, 32'd0, 32'h7FFF_FFFF));
		search_key(key_of(0, '0), 1'b0);
		search_key(key_of(2, 64'h6261), 1'b0);
		search_key(key_of(2, 64'h0061), 1'b0);
		search_key(key_of(4, 64'h7A797861), 1'b0);   // fails on 'x', rest ignored
		search_key(key_of(3, 64'h050AFF), 1'b0);     // transition below zero
		search_key(key_of(2, 64'hC8FF), 1'b0);       // transition past the table end
		// leaf rewritten while the key is open
		send_item(mk_byte(8'h61));
		send_item(mk_item(OP_SPARE));
		send_item(mk_write(16'd300, leaf_word(31'd7), 32'd300));
		send_item(mk_item(datrie_pkg::OP_END));
		wait_idle();
		program_search(1'b0, 16'hFFFF);
		search_key(key_of(1, 64'h61), 1'b0);
		search_key(key_of(0, '0), 1'b0);
		wait_idle();
		program_search(1'b0, 16'd10);
		search_key(key_of(2, 64'h6261), 1'b0);
	endtask

	task automatic run_trie_phase(bit mode, logic [datrie_pkg::IDX_W-1:0] start, int n_keys,
		int n_searches);
		trie_key_t k;
		int r;
		wait_idle();
		idle_on = ($urandom_range(3) != 0);
		program_search(mode, start);
		trie_child.delete();
		stored_keys.delete();
		next_block = 512 + $urandom_range(64);
		foreach (alphabet[i])
			alphabet[i] = datrie_pkg::BYTE_W'($urandom_range(255));
		trie_root = next_block;
		next_block += BLOCK_SPAN;
		send_item(mk_write(start, datrie_pkg::WORD_W'(trie_root), $urandom));
		for (int i = 0; i < n_keys; i++)
			insert_key(random_key(5, 1'b0));
		for (int i = 0; i < n_searches && items_sent < ITEM_TARGET; i++) begin
			r = $urandom_range(99);
			if (r < 65 && stored_keys.size() > 0) begin
				k = stored_keys[$urandom_range(stored_keys.size() - 1)];
				r = $urandom_range(9);
				if (r == 6 || r == 7) begin
					k.len = $urandom_range(k.len);
				end else if (r == 8) begin
					k.chars[k.len] = alphabet[$urandom_range(2)];
					k.len++;
				end else if (r == 9 && k.len > 0) begin
					k.chars[k.len - 1] = datrie_pkg::BYTE_W'($urandom_range(255));
				end
				search_key(k, $urandom_range(19) == 0);
			end else if (r < 85) begin
				search_key(random_key(6, 1'b0), 1'b0);
			end else if (r < 93) begin
				search_key(random_key(4, 1'b1), 1'b0);
			end else begin
				send_noise();
			end
		end
	endtask

	task automatic test_random_tries();
		int phase;
		logic [datrie_pkg::IDX_W-1:0] start;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase == 1)
				start = '0;
			else if (phase == 3)
				start = '1;
			else
				start = datrie_pkg::IDX_W'($urandom_range(400, 1));
			run_trie_phase(phase[0], start, $urandom_range(14, 6), $urandom_range(40, 25));
			phase++;
		end
		idle_on = 1'b1;
	endtask

	// result sink with random backpressure
	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp_hold--;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_hold = ($urandom_range(3) == 0) ? pick_gap() : 0;
			rsp_bus.ready <= (rsp_hold == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_matches.size() == 0) begin
				$error("result beat with nothing expected: kind %0d found %0d value %0d",
					rsp_bus.result_kind, rsp_bus.found, rsp_bus.match_value);
				error_count++;
			end else begin
				seen_exp = pending_matches.pop_front();
				if (rsp_bus.result_kind !== seen_exp.kind) begin
					$error("result_kind mismatch: expected %0d, got %0d",
						seen_exp.kind, rsp_bus.result_kind);
					error_count++;
				end
				if (rsp_bus.found !== seen_exp.found) begin
					$error("found mismatch: expected %0d, got %0d",
						seen_exp.found, rsp_bus.found);
					error_count++;
				end
				if (rsp_bus.match_value !== seen_exp.value) begin
					$error("match_value mismatch: expected %0d, got %0d",
						seen_exp.value, rsp_bus.match_value);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding",
				CYCLE_LIMIT, pending_matches.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_bus.valid       = 1'b0;
		req_bus.operation   = datrie_pkg::OP_WRITE;
		req_bus.entry_index = '0;
		req_bus.base_word   = '0;
		req_bus.check_word  = '0;
		req_bus.key_byte    = '0;
		rsp_bus.ready       = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.index       = datrie_pkg::CFG_SEARCH_MODE;
		cfg_bus.data        = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_tables();
		test_directed_trie();
		test_random_tries();

		wait_idle();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
